@@ src/dclrf_pkg.sv @@
`timescale 1ns / 1ps

package dclrf_pkg;

    // Default depth of the register store in 32-bit words.
    localparam int unsigned RF_REG_WORDS = 512;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned INDEX_W  = 10;
    localparam int unsigned CFG_W    = 3;
    localparam int unsigned CFG_IX_W = 2;
    localparam int unsigned PROT_W   = 5;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IX_W-1:0] CFG_SOC_GENERATION = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_RAM_SIZE_CODE  = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_START_UNLOCKED = 2'd2;

    // Controller generations.
    localparam logic [1:0] GEN_FIRST  = 2'd0;
    localparam logic [1:0] GEN_SECOND = 2'd1;
    localparam logic [1:0] GEN_THIRD  = 2'd2;
    localparam logic [1:0] GEN_FOURTH = 2'd3;

    // Key values and the protection states they leave in the key register.
    localparam logic [DATA_W-1:0] KEY_UNLOCK    = 32'hFC60_0309;
    localparam logic [DATA_W-1:0] KEY_UNLOCK_G3 = 32'h1688_A8A8;
    localparam logic [DATA_W-1:0] KEY_HARDLOCK  = 32'hDEAD_DEAD;

    localparam logic [PROT_W-1:0] PROT_SOFT = 5'h00;
    localparam logic [PROT_W-1:0] PROT_OPEN = 5'h01;
    localparam logic [PROT_W-1:0] PROT_HARD = 5'h10;

    localparam logic [DATA_W-1:0] RO_MASK_G0  = 32'hFFFF_F84C;
    localparam logic [DATA_W-1:0] RO_MASK_G12 = 32'hF00F_C04C;
    localparam logic [DATA_W-1:0] RO_MASK_G3  = 32'hFFFF_2082;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } rf_state_t;

    // Configuration word with its read-only bits kept and the fixed fields inserted.
    function automatic logic [DATA_W-1:0] conf_word(
        input logic [1:0]        gen,
        input logic [CFG_W-1:0]  size,
        input logic [DATA_W-1:0] data
    );
        logic [DATA_W-1:0] sz2;
        logic [DATA_W-1:0] res;
        sz2 = {30'd0, size[1:0]};
        unique case (gen)
            GEN_FIRST:  res = (data & ~RO_MASK_G0) | 32'h0000_0040 | sz2;
            GEN_SECOND: res = (data & ~RO_MASK_G12) | 32'h1008_000C | sz2;
            GEN_THIRD:  res = (data & ~RO_MASK_G12) | 32'h3000_000C | sz2;
            default:    res = (data & ~RO_MASK_G3) | 32'h0000_0020
                              | {27'd0, size, 2'b00};
        endcase
        return res;
    endfunction

    // Reset contents of one store word for the given configuration.
    function automatic logic [DATA_W-1:0] default_word(
        input logic [1:0]         gen,
        input logic [CFG_W-1:0]   size,
        input logic [INDEX_W-1:0] idx
    );
        logic [DATA_W-1:0] res;
        res = '0;
        if (gen == GEN_FOURTH) begin
            if (idx == 10'h004) begin
                res = conf_word(gen, size, '0);
            end
        end else begin
            unique case (idx)
                10'h001: res = conf_word(gen, size, '0);
                10'h100: res = 32'h0000_0002;
                10'h11A: res = 32'h0000_00FF;
                10'h11F: res = 32'h0000_00FF;
                10'h114: res = 32'h0FFF_FFFF;
                default: res = '0;
            endcase
        end
        return res;
    endfunction

    // Registers that stay writable whatever the lock state, on the third and fourth generations only.
    function automatic logic free_word(
        input logic [1:0]         gen,
        input logic [INDEX_W-1:0] idx
    );
        logic hit;
        hit = 1'b0;
        if (gen == GEN_THIRD) begin
            unique case (idx)
                10'h014, 10'h01B, 10'h01D, 10'h01E,
                10'h01F, 10'h022, 10'h023, 10'h02D: hit = 1'b1;
                default: hit = 1'b0;
            endcase
        end else if (gen == GEN_FOURTH) begin
            unique case (idx)
                10'h001, 10'h002, 10'h003, 10'h007, 10'h01E, 10'h01F,
                10'h025, 10'h035, 10'h036, 10'h037, 10'h038, 10'h039,
                10'h03D, 10'h03E, 10'h043,
                10'h090, 10'h091, 10'h092, 10'h0B0, 10'h0B1, 10'h0B2,
                10'h0D0, 10'h0D1, 10'h0D2, 10'h0F0, 10'h0F1, 10'h0F2,
                10'h110, 10'h111, 10'h112, 10'h130, 10'h131, 10'h132: hit = 1'b1;
                default: hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

endpackage

@@ src/dram_ctrl_locked_register_file_unit.sv @@
`timescale 1ns / 1ps

// Locked register file of a DRAM controller, one bus access per item.
// The s_ channel carries an access: s_opcode selects read or write, s_word_index is
// the byte offset divided by four and s_write_data the data of a write. The m_
// channel returns one result item per access: the read word, an out-of-range flag
// and a flag telling that a write was dropped by the lock.
// The cfg_ port writes the generation, the RAM size code and the start-unlocked
// strap; each such write reloads the store defaults, exactly as a reset does.
// A result is registered twice before it is valid on m_: once by the synchronous read
// of the store and once by the output register.
// Throughput is one item per cycle while the receiver keeps up; the single port of
// the store carries either the read or the write of an item, and the key register
// lives in flip-flops so a write never needs a read of the store first.
// After reset and after each write to one of these configuration registers, a
// clearing pass writes the defaults into all REG_WORDS words of the store, one
// word a cycle; s_ready stays low throughout. When the receiver stalls, the result
// waits in the output register and one more item waits behind it in the read
// stage; further items are held off with s_ready low and nothing is lost.
module dram_ctrl_locked_register_file_unit #(
    parameter int unsigned REG_WORDS = dclrf_pkg::RF_REG_WORDS
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_we,
    input  logic [dclrf_pkg::CFG_IX_W-1:0]     cfg_index,
    input  logic [dclrf_pkg::CFG_W-1:0]        cfg_wdata,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic [dclrf_pkg::INDEX_W-1:0]      s_word_index,
    input  logic [dclrf_pkg::DATA_W-1:0]       s_write_data,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [dclrf_pkg::DATA_W-1:0]       m_read_data,
    output logic                               m_out_of_range,
    output logic                               m_write_blocked
);
    import dclrf_pkg::*;

    localparam int unsigned AW = $clog2(REG_WORDS);
    localparam logic [AW-1:0] LAST_WORD = AW'(REG_WORDS - 1);
    localparam logic [INDEX_W:0] WORDS_L = (INDEX_W + 1)'(REG_WORDS);

    // Configuration registers.
    logic [1:0]       gen_reg;
    logic [CFG_W-1:0] size_reg;
    logic             start_unl_reg;
    logic             cfg_hit;

    // Sequencer.
    rf_state_t        state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;

    // The key register is kept outside the store.
    logic [PROT_W-1:0] prot_reg, prot_next;

    // Store port.
    logic [DATA_W-1:0] mem [REG_WORDS];
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_q;

    // Access decode.
    logic              accept, in_oor, is_write, is_key;
    logic              wr_store, wr_key, wr_blk;
    logic [DATA_W-1:0] wr_data;
    logic [PROT_W-1:0] key_val;

    // Read stage and output register.
    logic              pend_reg, pend_next;
    logic              pend_rd_reg, pend_key_reg, pend_oor_reg, pend_blk_reg;
    logic              out_load;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_read_data_reg;
    logic              m_out_of_range_reg, m_write_blocked_reg;

    assign cfg_hit = cfg_we && (cfg_index == CFG_SOC_GENERATION
                               || cfg_index == CFG_RAM_SIZE_CODE
                               || cfg_index == CFG_START_UNLOCKED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg       <= GEN_THIRD;
            size_reg      <= '0;
            start_unl_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SOC_GENERATION: gen_reg       <= cfg_wdata[1:0];
                CFG_RAM_SIZE_CODE:  size_reg      <= cfg_wdata;
                CFG_START_UNLOCKED: start_unl_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Next state of the sequencer: a valid configuration write restarts the
    // clearing pass, which ends at the last word.
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        priority if (cfg_hit) begin
            state_next   = ST_CLEAR;
            clr_cnt_next = '0;
        end else if (state_reg == ST_CLEAR) begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == LAST_WORD) begin
                state_next = ST_RUN;
            end
        end
    end

    assign accept   = s_valid && s_ready;
    assign in_oor   = {1'b0, s_word_index} >= WORDS_L;
    assign is_write = (s_opcode == OP_WRITE);
    assign is_key   = (s_word_index == '0);

    // Lock check and write-data shaping of one write access.
    always_comb begin
        wr_store = 1'b0;
        wr_key   = 1'b0;
        wr_blk   = 1'b0;
        wr_data  = s_write_data;
        key_val  = PROT_SOFT;
        if (gen_reg == GEN_FIRST || gen_reg == GEN_SECOND) begin
            // Older generations: any nonzero key state counts as unlocked.
            priority if (is_key) begin
                wr_key  = 1'b1;
                key_val = (s_write_data == KEY_UNLOCK) ? PROT_OPEN : PROT_SOFT;
            end else if (prot_reg == PROT_SOFT) begin
                wr_blk = 1'b1;
            end else begin
                wr_store = 1'b1;
                if (s_word_index == 10'h001) begin
                    wr_data = conf_word(gen_reg, size_reg, s_write_data);
                end else if (gen_reg == GEN_SECOND && s_word_index == 10'h018) begin
                    wr_data = s_write_data & ~32'h0000_0001;
                end else if (gen_reg == GEN_SECOND && s_word_index == 10'h01C) begin
                    wr_data = (s_write_data | 32'h0000_1000) & ~32'h0000_2000;
                end
            end
        end else begin
            priority if (free_word(gen_reg, s_word_index)) begin
                wr_store = 1'b1;
            end else if (prot_reg == PROT_HARD) begin
                wr_blk = 1'b1;
            end else if (!is_key && prot_reg == PROT_SOFT) begin
                wr_blk = 1'b1;
            end else if (is_key) begin
                wr_key = 1'b1;
                if (s_write_data == ((gen_reg == GEN_THIRD) ? KEY_UNLOCK : KEY_UNLOCK_G3)) begin
                    key_val = PROT_OPEN;
                end else if (s_write_data == KEY_HARDLOCK) begin
                    key_val = PROT_HARD;
                end
            end else begin
                wr_store = 1'b1;
                if (gen_reg == GEN_THIRD) begin
                    if (s_word_index == 10'h001) begin
                        wr_data = conf_word(gen_reg, size_reg, s_write_data);
                    end else if (s_word_index == 10'h018 || s_word_index == 10'h01C) begin
                        // Status words: done set, busy and failure clear.
                        wr_data = (s_word_index == 10'h018)
                                  ? ((s_write_data & ~32'h0000_0001) | 32'h0000_0010)
                                  : ((s_write_data | 32'h0000_1000) & ~32'h0000_2000);
                    end
                end else begin
                    if (s_word_index == 10'h004) begin
                        wr_data = conf_word(gen_reg, size_reg, s_write_data);
                    end else if (s_word_index == 10'h006) begin
                        wr_data = s_write_data & ~32'h0000_0001;
                    end
                end
            end
        end
    end

    assign out_load = pend_reg && (!m_valid_reg || m_ready);

    // Handshake and store port controls.
    always_comb begin
        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = s_word_index[AW-1:0];
        mem_wdata = wr_data;
        prot_next = prot_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = default_word(gen_reg, size_reg, INDEX_W'(clr_cnt_reg));
                if (clr_cnt_reg == '0) begin
                    prot_next = (gen_reg == GEN_FOURTH && start_unl_reg)
                                ? PROT_OPEN : PROT_SOFT;
                end
            end
            ST_RUN: begin
                s_ready = !pend_reg || out_load;
                if (accept && !in_oor) begin
                    mem_we = is_write && wr_store;
                    mem_re = !is_write;
                    if (is_write && wr_key) begin
                        prot_next = key_val;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q <= mem[mem_addr];
        end
    end

    assign pend_next    = accept || (pend_reg && !out_load);
    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            prot_reg    <= PROT_SOFT;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            prot_reg    <= prot_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload of the read stage and of the output register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_rd_reg  <= !is_write && !in_oor;
            pend_key_reg <= is_key;
            pend_oor_reg <= in_oor;
            pend_blk_reg <= is_write && !in_oor && wr_blk;
        end
        if (out_load) begin
            m_read_data_reg     <= !pend_rd_reg ? '0
                                   : (pend_key_reg ? DATA_W'(prot_reg) : mem_q);
            m_out_of_range_reg  <= pend_oor_reg;
            m_write_blocked_reg <= pend_blk_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_read_data     = m_read_data_reg;
    assign m_out_of_range  = m_out_of_range_reg;
    assign m_write_blocked = m_write_blocked_reg;

`ifndef SYNTHESIS
    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> pend_reg)
        else $error("accepted item did not reach the read stage");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg && !out_load |=> pend_reg && $stable(pend_oor_reg) && $stable(pend_blk_reg))
        else $error("stalled item in the read stage was lost or changed");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_out_of_range_reg && m_write_blocked_reg))
        else $error("result flagged both out of range and blocked");

    a_prot_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        prot_reg == PROT_SOFT || prot_reg == PROT_OPEN || prot_reg == PROT_HARD)
        else $error("key register holds an illegal protection state");

    a_cfg_restarts_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> state_reg == ST_CLEAR && clr_cnt_reg == '0)
        else $error("configuration write did not restart the clearing pass");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the locked register file. A shadow copy of the store,
// the key register and the strap registers is kept here. Every accepted access is
// run through it to give the result that the block must return. The driver and
// the result monitor are clocked processes: the driver works from a queue of
// accesses that the main initial block fills, phase by phase, between strap writes.
module testbench;

    import dclrf_pkg::*;

    localparam int unsigned WORDS       = RF_REG_WORDS;
    localparam int unsigned HOLD_AT     = 100;
    localparam int unsigned HOLD_CYCLES = 80;

    // The fourth register index is not implemented. A write to it must change nothing.
    localparam logic [CFG_IX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic               op;
        logic [INDEX_W-1:0] idx;
        logic [DATA_W-1:0]  data;
    } access_t;

    typedef struct packed {
        logic [DATA_W-1:0] rd;
        logic              oor;
        logic              blk;
    } reply_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CFG_IX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    logic                s_opcode  = OP_READ;
    logic [INDEX_W-1:0]  s_word_index = '0;
    logic [DATA_W-1:0]   s_write_data = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    logic [DATA_W-1:0]   m_read_data;
    logic                m_out_of_range;
    logic                m_write_blocked;

    // Shadow state of the block.
    logic [DATA_W-1:0] shadow_regs [0:WORDS-1];
    logic [1:0]        shadow_gen;
    logic [CFG_W-1:0]  shadow_size;
    logic              shadow_unlocked;

    // Registers that bypass the lock on the third and fourth generations.
    logic [INDEX_W-1:0] free_third [0:7] = '{
        10'h014, 10'h01B, 10'h01D, 10'h01E, 10'h01F, 10'h022, 10'h023, 10'h02D
    };
    logic [INDEX_W-1:0] free_fourth [0:32] = '{
        10'h001, 10'h002, 10'h003, 10'h007, 10'h01E, 10'h01F, 10'h025, 10'h035,
        10'h036, 10'h037, 10'h038, 10'h039, 10'h03D, 10'h03E, 10'h043,
        10'h090, 10'h091, 10'h092, 10'h0B0, 10'h0B1, 10'h0B2, 10'h0D0, 10'h0D1,
        10'h0D2, 10'h0F0, 10'h0F1, 10'h0F2, 10'h110, 10'h111, 10'h112, 10'h130,
        10'h131, 10'h132
    };
    // Modified-write and nonzero-reset words, the last store word and the first beyond it.
    logic [INDEX_W-1:0] odd_words [0:10] = '{
        10'h001, 10'h004, 10'h006, 10'h018, 10'h01C, 10'h100, 10'h114, 10'h11A,
        10'h11F, 10'h1FF, 10'h200
    };

    access_t           access_queue [$];
    reply_t            reply_queue [$];
    logic [INDEX_W-1:0] written_idx [$];
    access_t           next_acc;
    reply_t            want;

    int unsigned pushed_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned results_seen   = 0;
    int unsigned fail_count     = 0;
    int unsigned hold_left      = 0;
    logic        hold_done      = 1'b0;
    logic        quiet          = 1'b0;
    logic        s_taken        = 1'b0;

    dram_ctrl_locked_register_file_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_word_index    (s_word_index),
        .s_write_data    (s_write_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_out_of_range  (m_out_of_range),
        .m_write_blocked (m_write_blocked)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The configuration word with its read-only bits kept and the strap fields put in.
    function automatic logic [DATA_W-1:0] shadow_conf(input logic [DATA_W-1:0] data);
        logic [DATA_W-1:0] sz2;
        logic [DATA_W-1:0] res;
        sz2 = {30'd0, shadow_size[1:0]};
        case (shadow_gen)
            GEN_FIRST:  res = (data & ~RO_MASK_G0) | 32'h0000_0040 | sz2;
            GEN_SECOND: res = (data & ~RO_MASK_G12) | 32'h1008_000C | sz2;
            GEN_THIRD:  res = (data & ~RO_MASK_G12) | 32'h3000_000C | sz2;
            default:    res = (data & ~RO_MASK_G3) | 32'h0000_0020
                              | {27'd0, shadow_size, 2'b00};
        endcase
        return res;
    endfunction

    // Reload the store as reset leaves it for the present straps.
    function automatic void shadow_defaults();
        int unsigned i;
        for (i = 0; i < WORDS; i++) begin
            shadow_regs[i] = '0;
        end
        if (shadow_gen == GEN_FOURTH) begin
            shadow_regs[4] = shadow_conf('0);
            if (shadow_unlocked) begin
                shadow_regs[0] = 32'(PROT_OPEN);
            end
        end else begin
            shadow_regs[1]     = shadow_conf('0);
            shadow_regs[10'h100] = 32'h0000_0002;
            shadow_regs[10'h11A] = 32'h0000_00FF;
            shadow_regs[10'h11F] = 32'h0000_00FF;
            shadow_regs[10'h114] = 32'h0FFF_FFFF;
        end
    endfunction

    // A strap write acts as a strap change followed by a reset of the store.
    function automatic void shadow_config(input logic [CFG_IX_W-1:0] index,
                                          input logic [CFG_W-1:0] value);
        case (index)
            CFG_SOC_GENERATION: shadow_gen      = value[1:0];
            CFG_RAM_SIZE_CODE:  shadow_size     = value;
            CFG_START_UNLOCKED: shadow_unlocked = value[0];
            default:            return;
        endcase
        shadow_defaults();
    endfunction

    // Works out the result of one access and applies it to the shadow store.
    function automatic reply_t predict_reply(input logic op, input logic [INDEX_W-1:0] idx,
                                             input logic [DATA_W-1:0] data);
        reply_t            r;
        logic [DATA_W-1:0] prot;
        logic [DATA_W-1:0] w;
        logic [DATA_W-1:0] unlock_key;
        logic              free_hit;
        int unsigned       k;
        r        = '0;
        w        = data;
        prot     = shadow_regs[0];
        free_hit = 1'b0;
        if (idx >= WORDS) begin
            r.oor = 1'b1;
        end else if (op == OP_READ) begin
            r.rd = shadow_regs[idx];
        end else if (shadow_gen == GEN_FIRST || shadow_gen == GEN_SECOND) begin
            // Older parts: the key register is always writable and anything but
            // zero in it counts as unlocked.
            if (idx == 0) begin
                shadow_regs[0] = (data == KEY_UNLOCK) ? 32'(PROT_OPEN) : 32'(PROT_SOFT);
            end else if (prot == 0) begin
                r.blk = 1'b1;
            end else begin
                if (idx == 1) begin
                    w = shadow_conf(w);
                end else if (shadow_gen == GEN_SECOND && idx == 10'h018) begin
                    w = w & ~32'h1;
                end else if (shadow_gen == GEN_SECOND && idx == 10'h01C) begin
                    w = (w | 32'h1000) & ~32'h2000;
                end
                shadow_regs[idx] = w;
            end
        end else begin
            if (shadow_gen == GEN_THIRD) begin
                for (k = 0; k < 8; k++) begin
                    if (free_third[k] == idx) free_hit = 1'b1;
                end
            end else begin
                for (k = 0; k < 33; k++) begin
                    if (free_fourth[k] == idx) free_hit = 1'b1;
                end
            end
            unlock_key = (shadow_gen == GEN_THIRD) ? KEY_UNLOCK : KEY_UNLOCK_G3;
            if (free_hit) begin
                shadow_regs[idx] = data;
            end else if (prot == PROT_HARD) begin
                r.blk = 1'b1;
            end else if (idx != 0 && prot == PROT_SOFT) begin
                r.blk = 1'b1;
            end else begin
                if (idx == 0) begin
                    // A soft lock never stops a new key from being written.
                    if (data == unlock_key) w = 32'(PROT_OPEN);
                    else if (data == KEY_HARDLOCK) w = 32'(PROT_HARD);
                    else w = 32'(PROT_SOFT);
                end else if (shadow_gen == GEN_THIRD) begin
                    if (idx == 1) w = shadow_conf(w);
                    else if (idx == 10'h018) w = (w & ~32'h1) | 32'h10;
                    else if (idx == 10'h01C) w = (w | 32'h1000) & ~32'h2000;
                end else begin
                    if (idx == 4) w = shadow_conf(w);
                    else if (idx == 6) w = w & ~32'h1;
                end
                shadow_regs[idx] = w;
            end
        end
        return r;
    endfunction

    // One random access. Most of them aim at registers with special behaviour, at
    // the bypass list or at words written lately, so that reads see real data.
    function automatic access_t pick_access();
        access_t     a;
        int unsigned r;
        int unsigned d;
        r      = $urandom_range(99);
        d      = $urandom_range(9);
        a.op   = 1'($urandom_range(1));
        a.data = (d == 0) ? 32'h0 : (d == 1) ? 32'hFFFF_FFFF : $urandom;
        if (r < 8) begin
            a.op   = OP_WRITE;
            a.idx  = '0;
            a.data = (shadow_gen == GEN_FOURTH) ? KEY_UNLOCK_G3 : KEY_UNLOCK;
        end else if (r < 12) begin
            a.op  = OP_WRITE;
            a.idx = '0;
            case ($urandom_range(2))
                0:       a.data = KEY_UNLOCK;
                1:       a.data = KEY_UNLOCK_G3;
                default: a.data = $urandom;
            endcase
        end else if (r == 12) begin
            a.op   = OP_WRITE;
            a.idx  = '0;
            a.data = KEY_HARDLOCK;
        end else if (r < 40) begin
            a.idx = odd_words[$urandom_range(10)];
        end else if (r < 55) begin
            a.idx = (shadow_gen == GEN_FOURTH) ? free_fourth[$urandom_range(32)]
                                               : free_third[$urandom_range(7)];
        end else if (r < 73 && written_idx.size() != 0) begin
            a.op  = OP_READ;
            a.idx = written_idx[$urandom_range(written_idx.size() - 1)];
        end else if (r < 82) begin
            a.idx = INDEX_W'($urandom_range(10'h03F));
        end else if (r < 92) begin
            a.idx = INDEX_W'($urandom_range(WORDS - 1));
        end else begin
            a.idx = INDEX_W'($urandom_range(1023));
        end
        if (a.op == OP_WRITE && a.idx < WORDS) begin
            written_idx.push_back(a.idx);
            if (written_idx.size() > 16) void'(written_idx.pop_front());
        end
        return a;
    endfunction

    task automatic push_access(input logic op, input logic [INDEX_W-1:0] idx,
                               input logic [DATA_W-1:0] data);
        access_queue.push_back('{op: op, idx: idx, data: data});
        pushed_count++;
    endtask

    // Waits until every queued access has been taken and answered.
    task automatic drain();
        do @(negedge aclk);
        while (accepted_count != pushed_count || reply_queue.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // Strap write. On a used index the block then runs its clearing pass with s_ready
    // low, so the next write or access waits until it takes items again.
    task automatic write_cfg(input logic [CFG_IX_W-1:0] index, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        shadow_config(index, value);
        @(negedge aclk);
        cfg_we <= 1'b0;
        do @(posedge aclk);
        while (!s_ready);
    endtask

    // A phase opens with a look at the key and configuration words and an unlock,
    // then carries on with random accesses.
    task automatic run_phase(input int unsigned count);
        int unsigned n;
        push_access(OP_READ, '0, $urandom);
        push_access(OP_READ, (shadow_gen == GEN_FOURTH) ? 10'h004 : 10'h001, $urandom);
        push_access(OP_WRITE, '0, (shadow_gen == GEN_FOURTH) ? KEY_UNLOCK_G3 : KEY_UNLOCK);
        for (n = 0; n < count; n++) begin
            access_queue.push_back(pick_access());
            pushed_count++;
        end
        drain();
    endtask

    // Driver: a new item is put up only once the one on the bus has been taken.
    always @(negedge aclk) begin
        if (!s_valid || s_taken) begin
            if (access_queue.size() != 0 && (quiet || $urandom_range(99) >= 9)) begin
                next_acc = access_queue.pop_front();
                s_valid      <= 1'b1;
                s_opcode     <= next_acc.op;
                s_word_index <= next_acc.idx;
                s_write_data <= next_acc.data;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps going,
    // so that both stages of the block fill and s_ready drops.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 9);
        end
    end

    // Monitor and predictor. Results are checked before the access of the same
    // edge is predicted, so that a result can never match its own access.
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (reply_queue.size() == 0) begin
                if (fail_count < 10) begin
                    $display("result with nothing expected: read_data %h out_of_range %b %s %b",
                             m_read_data, m_out_of_range, "write_blocked", m_write_blocked);
                end
                fail_count++;
            end else begin
                want = reply_queue.pop_front();
                if (m_read_data !== want.rd || m_out_of_range !== want.oor
                        || m_write_blocked !== want.blk) begin
                    if (fail_count < 10) begin
                        $display("mismatch: read_data %h/%h out_of_range %b/%b %s %b/%b",
                                 want.rd, m_read_data, want.oor, m_out_of_range,
                                 "write_blocked (expected/actual)", want.blk, m_write_blocked);
                    end
                    fail_count++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            reply_queue.push_back(predict_reply(s_opcode, s_word_index, s_write_data));
            accepted_count++;
        end
    end

    initial begin
        shadow_gen      = GEN_THIRD;
        shadow_size     = '0;
        shadow_unlocked = 1'b0;
        shadow_defaults();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part on the reset straps: third generation, soft-locked.
        push_access(OP_READ,  10'h000, 32'h0);
        push_access(OP_READ,  10'h001, 32'h0);
        push_access(OP_READ,  10'h100, 32'h0);
        push_access(OP_READ,  10'h114, 32'h0);
        push_access(OP_READ,  10'h11A, 32'h0);
        push_access(OP_READ,  10'h11F, 32'hFFFF_FFFF);
        push_access(OP_WRITE, 10'h030, 32'hFFFF_FFFF);   // dropped by the soft lock
        push_access(OP_WRITE, 10'h014, 32'hA5A5_A5A5);   // on the bypass list
        push_access(OP_READ,  10'h014, 32'h0);
        push_access(OP_WRITE, 10'h000, KEY_UNLOCK);
        push_access(OP_READ,  10'h000, 32'h0);
        push_access(OP_WRITE, 10'h001, 32'hFFFF_FFFF);   // read-only bits of the conf word
        push_access(OP_READ,  10'h001, 32'h0);
        push_access(OP_WRITE, 10'h018, 32'hFFFF_FFFF);   // status shows done, not busy
        push_access(OP_READ,  10'h018, 32'h0);
        push_access(OP_WRITE, 10'h01C, 32'h0000_0000);   // ECC test shows done, no fail
        push_access(OP_READ,  10'h01C, 32'h0);
        push_access(OP_WRITE, 10'h1FF, 32'hFFFF_FFFF);   // last word of the store
        push_access(OP_READ,  10'h1FF, 32'h0);
        push_access(OP_READ,  10'h200, 32'h0);           // first word beyond it
        push_access(OP_WRITE, 10'h3FF, 32'hFFFF_FFFF);   // out-of-range write is ignored
        push_access(OP_WRITE, 10'h000, 32'h1234_5678);   // any other key soft-locks
        push_access(OP_WRITE, 10'h000, KEY_HARDLOCK);    // key still writable when soft-locked
        push_access(OP_WRITE, 10'h000, KEY_UNLOCK);      // refused once hard-locked
        push_access(OP_WRITE, 10'h014, 32'h0000_0000);
        push_access(OP_READ,  10'h000, 32'h0);
        drain();

        // First generation, top size code; the unused bit of the generation value
        // is set at random.
        write_cfg(CFG_SOC_GENERATION, {1'($urandom_range(1)), GEN_FIRST});
        write_cfg(CFG_RAM_SIZE_CODE, 3'd3);
        run_phase(50);

        // Second generation with a size code beyond the valid list; no idling at
        // all here, and the receiver's long hold-off falls in this phase.
        write_cfg(CFG_SOC_GENERATION, {1'b0, GEN_SECOND});
        write_cfg(CFG_RAM_SIZE_CODE, 3'd7);
        quiet = 1'b1;
        run_phase(50);
        quiet = 1'b0;

        // Fourth generation, new map, starting locked.
        write_cfg(CFG_SOC_GENERATION, {1'b1, GEN_FOURTH});
        write_cfg(CFG_RAM_SIZE_CODE, 3'd5);
        write_cfg(CFG_START_UNLOCKED, 3'b110);
        run_phase(50);

        // Fourth generation starting unlocked.
        write_cfg(CFG_RAM_SIZE_CODE, 3'd0);
        write_cfg(CFG_START_UNLOCKED, 3'b001);
        run_phase(50);

        // The unused index leaves straps and store alone.
        write_cfg(CFG_UNUSED, 3'b111);
        run_phase(20);

        write_cfg(CFG_SOC_GENERATION, {1'b0, GEN_THIRD});
        write_cfg(CFG_RAM_SIZE_CODE, 3'd2);
        run_phase(50);

        write_cfg(CFG_SOC_GENERATION, {1'b1, GEN_SECOND});
        write_cfg(CFG_RAM_SIZE_CODE, 3'd4);
        write_cfg(CFG_START_UNLOCKED, 3'b000);
        run_phase(50);

        write_cfg(CFG_SOC_GENERATION, {1'b0, GEN_FOURTH});
        write_cfg(CFG_RAM_SIZE_CODE, 3'd7);
        run_phase(40);

        repeat (6) @(posedge aclk);
        if (fail_count == 0 && reply_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ dram_ctrl_locked_register_file_unit.f @@
src/dclrf_pkg.sv
src/dram_ctrl_locked_register_file_unit.sv
test/testbench.sv
